// ----- rtl/core/cps_pkg.sv -----
`timescale 1ns / 1ps
package cps_pkg;

   // table size default
   localparam int SLOTS_DEF = 16;

   // register indexes and reset values
   localparam logic [7:0] CSR_MODE      = 8'd0;
   localparam logic [7:0] CSR_QUANTUM   = 8'd1;
   localparam logic [1:0] MODE_RR       = 2'd0;
   localparam logic [1:0] MODE_SRT      = 2'd1;
   localparam logic [1:0] MODE_PRIO     = 2'd2;
   // spare mode code, runs as priority
   localparam logic [1:0] MODE_PRIO_ALT = 2'd3;
   localparam logic [7:0] QUANTUM_RST   = 8'd4;

   // request kinds
   localparam logic KIND_ARRIVAL = 1'b0;
   localparam logic KIND_TICK    = 1'b1;

   localparam int REQ_W = 32;
   localparam int RSP_W = 80;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FREE, ST_STORE, ST_RR_PUSH, ST_RR_POP, ST_RR_POPD, ST_CUR_PUSH, ST_SCAN,
      ST_SCAN_END, ST_SEL_RD, ST_EXEC, ST_FINISH, ST_RM_RD, ST_RM_WR, ST_RM_END, ST_POST
   } cps_state_type;

   typedef struct packed {
      logic latch;
      logic free_step;
      logic store;
      logic rr_push;
      logic rr_pop;
      logic rr_popd;
      logic cur_push;
      logic scan_step;
      logic sel_rd;
      logic exec;
      logic finish;
      logic tick_idle;
      logic rm_rd;
      logic rm_wr;
      logic rm_end;
      logic post;
   } cps_cmd_type;

   typedef struct packed {
      logic req_kind;
      logic req_burst_zero;
      logic mode_rr;
      logic free_hit;
      logic free_last;
      logic cur_valid;
      logic fifo_nonempty;
      logic scan_done;
      logic found;
      logic done;
      logic rm_done;
      logic out_free;
   } cps_stat_type;

   // clamp to 16 bits
   function automatic logic [15:0] sat16(input logic [31:0] v);
      return (v > 32'd65535) ? 16'hFFFF : v[15:0];
   endfunction

endpackage

// ----- rtl/core/cps_ctrl.sv -----
`timescale 1ns / 1ps
module cps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 in_ready,
   output cps_pkg::cps_cmd_type cmd,
   input  cps_pkg::cps_stat_type stat
);
   import cps_pkg::*;

   cps_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               if (stat.req_kind == KIND_TICK) begin
                  state_in = stat.mode_rr ? ST_RR_PUSH : ST_CUR_PUSH;
               end else if (stat.req_burst_zero) begin
                  state_in = ST_POST;
               end else begin
                  state_in = ST_FREE;
               end
            end
         end
         ST_FREE: begin
            cmd.free_step = 1'b1;
            if (stat.free_hit) begin
               state_in = ST_STORE;
            end else if (stat.free_last) begin
               state_in = ST_POST;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = ST_POST;
         end
         ST_RR_PUSH: begin
            cmd.rr_push = 1'b1;
            state_in    = ST_RR_POP;
         end
         ST_RR_POP: begin
            cmd.rr_pop = 1'b1;
            if (stat.cur_valid) begin
               state_in = ST_SEL_RD;
            end else if (stat.fifo_nonempty) begin
               state_in = ST_RR_POPD;
            end else begin
               cmd.tick_idle = 1'b1;
               state_in      = ST_POST;
            end
         end
         ST_RR_POPD: begin
            cmd.rr_popd = 1'b1;
            state_in    = ST_SEL_RD;
         end
         ST_CUR_PUSH: begin
            cmd.cur_push = 1'b1;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            if (stat.found) begin
               state_in = ST_SEL_RD;
            end else begin
               cmd.tick_idle = 1'b1;
               state_in      = ST_POST;
            end
         end
         ST_SEL_RD: begin
            cmd.sel_rd = 1'b1;
            state_in   = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = (stat.done && !stat.mode_rr) ? ST_RM_RD : ST_POST;
         end
         ST_RM_RD: begin
            if (stat.rm_done) begin
               state_in = ST_RM_END;
            end else begin
               cmd.rm_rd = 1'b1;
               state_in  = ST_RM_WR;
            end
         end
         ST_RM_WR: begin
            cmd.rm_wr = 1'b1;
            state_in  = ST_RM_RD;
         end
         ST_RM_END: begin
            cmd.rm_end = 1'b1;
            state_in   = ST_POST;
         end
         ST_POST: begin
            if (stat.out_free) begin
               cmd.post = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- rtl/core/cps_dp.sv -----
`timescale 1ns / 1ps
module cps_dp #(
   parameter int SLOTS = cps_pkg::SLOTS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cps_pkg::cps_cmd_type     cmd,
   output cps_pkg::cps_stat_type    stat,
   input  logic [cps_pkg::REQ_W-1:0] req_tdata,
   input  logic                     req_tuser,
   input  logic                     csr_valid,
   input  logic [7:0]               csr_index,
   input  logic [7:0]               csr_data,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [cps_pkg::RSP_W-1:0] rsp_tdata
);
   import cps_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [IW-1:0] SLOT_LAST = IW'(SLOTS - 1);
   localparam logic [CW-1:0] SLOT_CNT  = CW'(SLOTS);

   function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
      return (p == SLOT_LAST) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [IW-1:0] ptr_dec(input logic [IW-1:0] p);
      return (p == '0) ? SLOT_LAST : p - 1'b1;
   endfunction

   // configuration
   logic [1:0] mode_ff;
   logic [7:0] quantum_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_RR;
         quantum_ff <= QUANTUM_RST;
      end else if (csr_valid) begin
         if (csr_index == CSR_MODE) begin
            mode_ff <= csr_data[1:0];
         end else if (csr_index == CSR_QUANTUM) begin
            quantum_ff <= csr_data;
         end
      end
   end

   logic       mode_rr;
   logic [7:0] q_eff;
   assign mode_rr = (mode_ff == MODE_RR);
   assign q_eff   = (quantum_ff == 8'd0) ? 8'd1 : quantum_ff;

   // latched request fields
   logic [7:0]  in_id_ff;
   logic [15:0] in_burst_ff;
   logic [7:0]  in_prio_ff;
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         in_id_ff    <= req_tdata[7:0];
         in_burst_ff <= req_tdata[23:8];
         in_prio_ff  <= req_tdata[31:24];
      end
   end

   // scheduler registers
   logic [SLOTS-1:0] valid_ff, started_ff;
   logic [31:0]      time_ff;
   logic [IW-1:0]    head_ff, tail_ff, cur_ff, sel_ff, free_ff;
   logic [CW-1:0]    count_ff;
   logic             cur_valid_ff;
   logic [7:0]       slice_ff;
   logic [CW-1:0]    scan_ff;
   logic             cmp_v_ff, found_ff;
   logic [IW-1:0]    cmp_slot_ff;
   logic [15:0]      best_key_ff;
   logic [31:0]      best_age_ff;
   logic [7:0]       best_id_ff;
   logic [IW-1:0]    rm_ptr_ff, rm_prev_ff;
   logic [CW-1:0]    rm_k_ff;
   logic             rm_seen_ff;
   logic             done_ff;
   logic [31:0]      elapsed_ff, resp_diff_ff;
   logic [15:0]      burst_ff;

   // entry stores
   logic [7:0]  ent_id_mem    [SLOTS];
   logic [15:0] ent_rem_mem   [SLOTS];
   logic [15:0] ent_burst_mem [SLOTS];
   logic [7:0]  ent_urg_mem   [SLOTS];
   logic [31:0] ent_arr_mem   [SLOTS];
   logic [31:0] ent_first_mem [SLOTS];
   logic [7:0]  ent_id_rd, ent_urg_rd;
   logic [15:0] ent_rem_rd, ent_burst_rd;
   logic [31:0] ent_arr_rd, ent_first_rd;
   logic [IW-1:0] ent_addr;
   logic [15:0]   rem_dec;

   assign rem_dec = ent_rem_rd - 16'd1;

   always_comb begin
      if (cmd.sel_rd) begin
         ent_addr = sel_ff;
      end else if (scan_ff < SLOT_CNT) begin
         ent_addr = scan_ff[IW-1:0];
      end else begin
         ent_addr = '0;
      end
   end

   // entry store writes and registered reads
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         ent_id_mem[free_ff]    <= in_id_ff;
         ent_rem_mem[free_ff]   <= in_burst_ff;
         ent_burst_mem[free_ff] <= in_burst_ff;
         ent_urg_mem[free_ff]   <= in_prio_ff;
         ent_arr_mem[free_ff]   <= time_ff;
      end
      if (cmd.exec) begin
         ent_rem_mem[sel_ff] <= rem_dec;
         if (!started_ff[sel_ff]) begin
            ent_first_mem[sel_ff] <= time_ff;
         end
      end
      ent_id_rd    <= ent_id_mem[ent_addr];
      ent_rem_rd   <= ent_rem_mem[ent_addr];
      ent_burst_rd <= ent_burst_mem[ent_addr];
      ent_urg_rd   <= ent_urg_mem[ent_addr];
      ent_arr_rd   <= ent_arr_mem[ent_addr];
      ent_first_rd <= ent_first_mem[ent_addr];
   end

   // ready queue memory
   logic [IW-1:0] fifo_mem [SLOTS];
   logic [IW-1:0] fifo_rd, fifo_raddr, fifo_waddr, fifo_wdata;
   logic          fifo_we, fifo_room, rr_expire;

   assign fifo_room = (count_ff < SLOT_CNT);
   assign rr_expire = cur_valid_ff && (slice_ff >= q_eff);
   assign fifo_raddr = cmd.rm_rd ? rm_ptr_ff : head_ff;

   always_comb begin
      fifo_we    = 1'b0;
      fifo_waddr = tail_ff;
      fifo_wdata = cur_ff;
      if (cmd.store) begin
         fifo_we    = fifo_room;
         fifo_wdata = free_ff;
      end else if ((cmd.rr_push && rr_expire) || (cmd.cur_push && cur_valid_ff)) begin
         fifo_we = fifo_room;
      end else if (cmd.rm_wr && rm_seen_ff && (fifo_rd != sel_ff)) begin
         fifo_we    = 1'b1;
         fifo_waddr = rm_prev_ff;
         fifo_wdata = fifo_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[fifo_waddr] <= fifo_wdata;
      end
      fifo_rd <= fifo_mem[fifo_raddr];
   end

   // queue pointers, turn holder and slice count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cur_ff       <= '0;
         cur_valid_ff <= 1'b0;
         slice_ff     <= '0;
      end else begin
         if (cmd.store && fifo_room) begin
            tail_ff  <= ptr_inc(tail_ff);
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.rr_push && rr_expire) begin
            if (fifo_room) begin
               tail_ff  <= ptr_inc(tail_ff);
               count_ff <= count_ff + 1'b1;
            end
            cur_valid_ff <= 1'b0;
         end
         if (cmd.rr_pop && !cur_valid_ff && (count_ff != '0)) begin
            head_ff  <= ptr_inc(head_ff);
            count_ff <= count_ff - 1'b1;
         end
         if (cmd.rr_popd) begin
            cur_ff       <= fifo_rd;
            cur_valid_ff <= 1'b1;
            slice_ff     <= '0;
         end
         if (cmd.cur_push && cur_valid_ff) begin
            if (fifo_room) begin
               tail_ff  <= ptr_inc(tail_ff);
               count_ff <= count_ff + 1'b1;
            end
            cur_valid_ff <= 1'b0;
            slice_ff     <= '0;
         end
         if (cmd.exec && mode_rr && (slice_ff != 8'hFF)) begin
            slice_ff <= slice_ff + 8'd1;
         end
         if (cmd.finish && done_ff && mode_rr) begin
            cur_valid_ff <= 1'b0;
            slice_ff     <= '0;
         end
         if (cmd.rm_end) begin
            tail_ff  <= ptr_dec(tail_ff);
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // scan compare
   logic [15:0] key_i;
   logic [31:0] age_i;
   logic        better;
   assign key_i = (mode_ff == MODE_SRT) ? ent_rem_rd : {8'd0, ent_urg_rd};
   assign age_i = time_ff - ent_arr_rd;
   always_comb begin
      if (!found_ff) begin
         better = 1'b1;
      end else if (key_i != best_key_ff) begin
         better = (key_i < best_key_ff);
      end else if (age_i != best_age_ff) begin
         better = (age_i > best_age_ff);
      end else begin
         better = (ent_id_rd < best_id_ff);
      end
   end

   // table scan and selected entry
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff  <= '0;
         cmp_v_ff <= 1'b0;
         found_ff <= 1'b0;
         sel_ff   <= '0;
      end else begin
         if (cmd.cur_push) begin
            scan_ff  <= '0;
            cmp_v_ff <= 1'b0;
            found_ff <= 1'b0;
         end
         if (cmd.scan_step) begin
            cmp_v_ff    <= (scan_ff < SLOT_CNT) && valid_ff[ent_addr];
            cmp_slot_ff <= ent_addr;
            scan_ff     <= scan_ff + 1'b1;
            if (cmp_v_ff && better) begin
               found_ff    <= 1'b1;
               best_key_ff <= key_i;
               best_age_ff <= age_i;
               best_id_ff  <= ent_id_rd;
               sel_ff      <= cmp_slot_ff;
            end
         end
         if (cmd.rr_pop && cur_valid_ff) begin
            sel_ff <= cur_ff;
         end
         if (cmd.rr_popd) begin
            sel_ff <= fifo_rd;
         end
      end
   end

   // result staging
   logic        res_acc_ff, res_idle_ff, res_done_ff;
   logic [7:0]  res_id_ff;
   logic [31:0] res_start_ff;
   logic [15:0] res_wait_ff, res_resp_ff;
   logic [31:0] wait_raw;
   assign wait_raw = (elapsed_ff >= {16'd0, burst_ff}) ? elapsed_ff - {16'd0, burst_ff} : 32'd0;

   // entry flags, time and free slot search
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         started_ff <= '0;
         time_ff    <= '0;
         free_ff    <= '0;
      end else begin
         if (cmd.latch) begin
            free_ff <= '0;
         end
         if (cmd.free_step && valid_ff[free_ff] && (free_ff != SLOT_LAST)) begin
            free_ff <= free_ff + 1'b1;
         end
         if (cmd.store) begin
            valid_ff[free_ff]   <= 1'b1;
            started_ff[free_ff] <= 1'b0;
         end
         if (cmd.exec) begin
            started_ff[sel_ff] <= 1'b1;
            time_ff            <= time_ff + 32'd1;
         end
         if (cmd.tick_idle) begin
            time_ff <= time_ff + 32'd1;
         end
         if (cmd.finish && done_ff) begin
            valid_ff[sel_ff]   <= 1'b0;
            started_ff[sel_ff] <= 1'b0;
         end
      end
   end

   // run one time unit and completion figures
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         res_acc_ff   <= 1'b0;
         res_idle_ff  <= 1'b0;
         res_done_ff  <= 1'b0;
         res_id_ff    <= '0;
         res_start_ff <= '0;
         res_wait_ff  <= '0;
         res_resp_ff  <= '0;
      end
      if (cmd.store) begin
         res_acc_ff <= 1'b1;
      end
      if (cmd.tick_idle) begin
         res_idle_ff  <= 1'b1;
         res_start_ff <= time_ff;
      end
      if (cmd.exec) begin
         res_id_ff    <= ent_id_rd;
         res_start_ff <= time_ff;
         done_ff      <= (rem_dec == 16'd0);
         burst_ff     <= ent_burst_rd;
         elapsed_ff   <= time_ff + 32'd1 - ent_arr_rd;
         resp_diff_ff <= (started_ff[sel_ff] ? ent_first_rd : time_ff) - ent_arr_rd;
      end
      if (cmd.finish && done_ff) begin
         res_done_ff <= 1'b1;
         res_wait_ff <= sat16(wait_raw);
         res_resp_ff <= sat16(resp_diff_ff);
      end
   end

   // queue removal walk
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rm_ptr_ff  <= head_ff;
         rm_k_ff    <= '0;
         rm_seen_ff <= 1'b0;
      end
      if (cmd.rm_wr) begin
         if (fifo_rd == sel_ff) begin
            rm_seen_ff <= 1'b1;
         end
         rm_prev_ff <= rm_ptr_ff;
         rm_ptr_ff  <= ptr_inc(rm_ptr_ff);
         rm_k_ff    <= rm_k_ff + 1'b1;
      end
   end

   // output register
   logic            rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.post) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.post) begin
         rsp_data_ff <= {5'd0, res_resp_ff, res_wait_ff, res_done_ff, res_start_ff,
                         res_id_ff, res_idle_ff, res_acc_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // status to the controller
   always_comb begin
      stat.req_kind       = req_tuser;
      stat.req_burst_zero = (req_tdata[23:8] == 16'd0);
      stat.mode_rr        = mode_rr;
      stat.free_hit       = !valid_ff[free_ff];
      stat.free_last      = (free_ff == SLOT_LAST);
      stat.cur_valid      = cur_valid_ff;
      stat.fifo_nonempty  = (count_ff != '0);
      stat.scan_done      = (scan_ff == SLOT_CNT);
      stat.found          = found_ff;
      stat.done           = done_ff;
      stat.rm_done        = (rm_k_ff == count_ff);
      stat.out_free       = !rsp_valid_ff || rsp_tready;
   end

endmodule

// ----- rtl/core/cpu_process_scheduler_top.sv -----
`timescale 1ns / 1ps
// Process scheduler over a table of SLOTS ready processes.
// Request channel req_*: one request per handshake, arrival (store a process) or
// tick (run one time unit). Result channel rsp_*: exactly one result per request.
// Configuration channel csr_*: index 0 scheduling mode, index 1 round-robin quantum;
// always ready. The user must see that it is written only while no request is in flight;
// the block does not enforce this. An arrival searches the table for a free slot, one
// slot per cycle; a zero burst skips the search and a full table leaves it unaccepted.
// A round-robin tick requeues an expired turn, starts a new turn from the ready queue
// if none is running and runs it. A shortest-remaining or priority tick scans the table
// through the single read port of the entry store, runs the best entry and, on
// completion, walks the ready queue of N entries to close the gap left by it.
// One request is processed at a time; the next one is taken in the cycle after the
// current result is posted to the output register, even if the receiver has not taken it.
// A stalled receiver holds the result in place and the block waits before posting
// the following result. Reset is synchronous: table empty, queue empty, time zero,
// mode round robin, quantum 4. No clearing pass is needed.
module cpu_process_scheduler_top #(
   parameter int SLOTS = cps_pkg::SLOTS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // [7:0] proc_id, [23:8] burst_len, [31:24] prio_level
   input  logic [cps_pkg::REQ_W-1:0] req_tdata,
   // [0] kind
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [0] accepted, [1] cpu_idle, [9:2] running_id, [41:10] slot_start,
   // [42] proc_done, [58:43] wait_time, [74:59] response_time, [79:75] zero
   output logic [cps_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [7:0]                csr_index,
   input  logic [7:0]                csr_data
);
   import cps_pkg::*;

   cps_cmd_type  cmd;
   cps_stat_type stat;

   assign csr_ready = 1'b1;

   cps_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .in_ready (req_tready),
      .cmd      (cmd),
      .stat     (stat)
   );

   cps_dp #(.SLOTS(SLOTS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // one request at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another is in flight");

   // a result only appears when the controller posts one
   a_post_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.post))
      else $error("result raised without a post command");

   // completion only on a tick that ran a process
   a_done_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[42]) |-> (!rsp_tdata[0] && !rsp_tdata[1]))
      else $error("completion flagged on arrival or idle tick");

   // removal walk only outside round robin
   a_rm_mode: assert property (@(posedge clock) disable iff (reset)
      cmd.rm_rd |-> !stat.mode_rr)
      else $error("queue removal in round-robin mode");

endmodule
